>>> design/block_convolutional_deinterleaver_defines.svh
// ----------------------------------------------------------------------------
// Block convolutional deinterleaver assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef BLOCK_CONVOLUTIONAL_DEINTERLEAVER_DEFINES_SVH
`define BLOCK_CONVOLUTIONAL_DEINTERLEAVER_DEFINES_SVH

// same-cycle implication
`define BCDI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bcdi check failed");

// next-cycle implication
`define BCDI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bcdi check failed");

`endif

>>> design/bcdi_pkg.sv
// ----------------------------------------------------------------------------
// Block convolutional deinterleaver package
// Shared constants, payload types and address helpers.
// ----------------------------------------------------------------------------
package bcdi_pkg;

	localparam int WORD_BITS      = 8;
	localparam int ROW_WORDS      = 120;
	localparam int HIST_ROWS      = 9;
	localparam int HIST_DEPTH     = HIST_ROWS * ROW_WORDS;
	localparam int ADDR_BITS      = $clog2(HIST_DEPTH);
	localparam int COL_BITS       = 7;
	localparam int ROW_BITS       = 7;
	localparam int SLOT_BITS      = $clog2(HIST_ROWS);
	localparam int GRP_BITS       = 4;
	localparam int FIRST_SENT_ROW = 7;
	localparam int PERM_STRIDE    = 10;
	localparam int PERM_GROUP     = ROW_WORDS / PERM_STRIDE;
	localparam int MIN_ROWS       = 8;
	localparam int RPF_RESET      = 12;
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS      = QPTR_BITS + 1;

	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic                 op;
		logic [WORD_BITS-1:0] data_word;
	} bcdi_in_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] out_word;
		logic [COL_BITS-1:0]  out_column;
		logic                 last_of_row;
		logic                 last_of_frame;
	} bcdi_out_t;

	typedef struct packed {
		logic [COL_BITS-1:0] out_column;
		logic                last_of_row;
		logic                last_of_frame;
	} bcdi_meta_t;

	typedef struct packed {
		logic                 rd_en;
		logic [ADDR_BITS-1:0] rd_addr;
		logic                 wr_en;
		logic [ADDR_BITS-1:0] wr_addr;
		logic [WORD_BITS-1:0] wr_data;
		bcdi_meta_t           meta;
	} bcdi_req_t;

	typedef struct packed {
		logic      valid;
		bcdi_out_t data;
	} bcdi_push_t;

	// slot * 120 as slot * 128 - slot * 8
	function automatic logic [ADDR_BITS-1:0] hist_addr(input logic [SLOT_BITS-1:0] slot,
		input logic [COL_BITS-1:0] col);
		logic [ADDR_BITS-1:0] base;
		base = {slot, 7'd0} - ADDR_BITS'({slot, 3'd0});
		return base + ADDR_BITS'(col);
	endfunction

	// step back k rows modulo HIST_ROWS, k at most HIST_ROWS - 1
	function automatic logic [SLOT_BITS-1:0] slot_back(input logic [SLOT_BITS-1:0] slot,
		input logic [SLOT_BITS-1:0] k);
		logic [SLOT_BITS:0] wrap;
		wrap = {1'b0, slot} + (SLOT_BITS+1)'(HIST_ROWS) - {1'b0, k};
		if (slot >= k) begin
			return slot - k;
		end else begin
			return wrap[SLOT_BITS-1:0];
		end
	endfunction

endpackage

>>> design/bcdi_front.sv
// ----------------------------------------------------------------------------
// Block convolutional deinterleaver front end
// Accepts words, tracks row and column, classifies each word and issues
// history reads and writes.
// ----------------------------------------------------------------------------
module bcdi_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  bcdi_pkg::bcdi_in_t           in_data,
	input  logic                         cfg_wr_en,
	input  logic [bcdi_pkg::ROW_BITS-1:0] cfg_wr_data,
	output bcdi_pkg::bcdi_req_t          req
);
	import bcdi_pkg::*;

	localparam logic [COL_BITS-1:0]  LAST_COL  = COL_BITS'(ROW_WORDS - 1);
	localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(HIST_ROWS - 1);
	localparam logic [GRP_BITS-1:0]  LAST_REM  = GRP_BITS'(PERM_GROUP - 1);

	logic [COL_BITS-1:0]  col_q, col_n;
	logic [GRP_BITS-1:0]  grp_q, grp_n;
	logic [GRP_BITS-1:0]  rem_q, rem_n;
	logic [ROW_BITS-1:0]  row_q, row_n;
	logic [SLOT_BITS-1:0] slot_q, slot_n;
	logic                 drain_q, drain_n;
	logic [COL_BITS-1:0]  dcol_q, dcol_n;
	logic [ROW_BITS-1:0]  rpf_q;
	logic [ROW_BITS-1:0]  frame_rows;
	logic [ROW_BITS:0]    row_inc;
	logic [COL_BITS-1:0]  dest;
	logic                 accept;

	assign accept     = in_valid && !in_stall;
	assign frame_rows = (rpf_q < ROW_BITS'(MIN_ROWS)) ? ROW_BITS'(MIN_ROWS) : rpf_q;
	assign row_inc    = {1'b0, row_q} + (ROW_BITS+1)'(1);
	assign dest       = COL_BITS'(grp_q) + COL_BITS'(rem_q) * COL_BITS'(PERM_STRIDE);

	always_comb begin
		req     = '0;
		col_n   = col_q;
		grp_n   = grp_q;
		rem_n   = rem_q;
		row_n   = row_q;
		slot_n  = slot_q;
		drain_n = drain_q;
		dcol_n  = dcol_q;
		if (accept) begin
			if (in_data.op == OP_DRAIN) begin
				if (drain_q) begin
					req.rd_en = 1'b1;
					req.rd_addr = hist_addr(slot_back(slot_q, SLOT_BITS'(dcol_q[2:0])), dcol_q);
					req.meta.out_column    = dcol_q;
					req.meta.last_of_row   = (dcol_q == LAST_COL);
					req.meta.last_of_frame = (dcol_q == LAST_COL);
					if (dcol_q == LAST_COL) begin
						drain_n = 1'b0;
						dcol_n  = '0;
						row_n   = '0;
						slot_n  = '0;
						col_n   = '0;
						grp_n   = '0;
						rem_n   = '0;
					end else begin
						dcol_n = dcol_q + COL_BITS'(1);
					end
				end
			end else if (!drain_q) begin
				if (row_q > ROW_BITS'(FIRST_SENT_ROW)) begin
					req.rd_en = 1'b1;
					req.rd_addr = hist_addr(slot_back(slot_q,
						SLOT_BITS'(col_q[2:0]) + SLOT_BITS'(1)), col_q);
					req.meta.out_column  = col_q;
					req.meta.last_of_row = (col_q == LAST_COL);
				end
				req.wr_en   = 1'b1;
				req.wr_addr = hist_addr(slot_q, dest);
				req.wr_data = in_data.data_word;
				if (col_q == LAST_COL) begin
					col_n = '0;
					grp_n = '0;
					rem_n = '0;
					if (row_inc >= {1'b0, frame_rows}) begin
						drain_n = 1'b1;
						dcol_n  = '0;
					end else begin
						row_n  = row_inc[ROW_BITS-1:0];
						slot_n = (slot_q == LAST_SLOT) ? '0 : slot_q + SLOT_BITS'(1);
					end
				end else begin
					col_n = col_q + COL_BITS'(1);
					if (rem_q == LAST_REM) begin
						rem_n = '0;
						grp_n = grp_q + GRP_BITS'(1);
					end else begin
						rem_n = rem_q + GRP_BITS'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			grp_q   <= '0;
			rem_q   <= '0;
			row_q   <= '0;
			slot_q  <= '0;
			drain_q <= 1'b0;
			dcol_q  <= '0;
			rpf_q   <= ROW_BITS'(RPF_RESET);
		end else begin
			col_q   <= col_n;
			grp_q   <= grp_n;
			rem_q   <= rem_n;
			row_q   <= row_n;
			slot_q  <= slot_n;
			drain_q <= drain_n;
			dcol_q  <= dcol_n;
			if (cfg_wr_en) begin
				rpf_q <= cfg_wr_data;
			end
		end
	end

endmodule

>>> design/bcdi_hist.sv
// ----------------------------------------------------------------------------
// Block convolutional deinterleaver row history
// Nine-row word memory with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bcdi_hist (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcdi_pkg::bcdi_req_t  req,
	output bcdi_pkg::bcdi_push_t push
);
	import bcdi_pkg::*;

	logic [WORD_BITS-1:0] mem [HIST_DEPTH];
	logic [WORD_BITS-1:0] rd_word_s1;
	bcdi_meta_t           meta_s1;
	logic                 valid_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_word_s1 <= mem[req.rd_addr];
			meta_s1    <= req.meta;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.rd_en;
		end
	end

	assign push.valid              = valid_s1;
	assign push.data.out_word      = rd_word_s1;
	assign push.data.out_column    = meta_s1.out_column;
	assign push.data.last_of_row   = meta_s1.last_of_row;
	assign push.data.last_of_frame = meta_s1.last_of_frame;

endmodule

>>> design/bcdi_queue.sv
// ----------------------------------------------------------------------------
// Block convolutional deinterleaver result queue
// Four-entry register queue that feeds the output channel.
// ----------------------------------------------------------------------------
module bcdi_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  bcdi_pkg::bcdi_push_t               push,
	input  logic                               out_stall,
	output logic                               out_valid,
	output bcdi_pkg::bcdi_out_t                out_data,
	output logic [bcdi_pkg::QCNT_BITS-1:0]     level
);
	import bcdi_pkg::*;

	bcdi_out_t            fifo_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] cnt_q;
	logic                 pop;

	assign out_valid = (cnt_q != '0);
	assign out_data  = fifo_q[rd_ptr_q];
	assign level     = cnt_q;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			fifo_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + QCNT_BITS'(1);
			end else if (!push.valid && pop) begin
				cnt_q <= cnt_q - QCNT_BITS'(1);
			end
		end
	end

endmodule

>>> design/block_convolutional_deinterleaver.sv
// ----------------------------------------------------------------------------
// Block convolutional deinterleaver
// Input channel in_valid/in_stall/in_data carries one word a cycle: op 0 is
// an interleaved data word, op 1 a drain tick for the last row of a frame.
// Output channel out_valid/out_stall/out_data carries the deinterleaved word,
// its column, and row-end and frame-end flags. cfg_wr_en/cfg_wr_data write
// rows_per_frame (reset 12); the user must do so only while the block is
// idle, the block does not enforce it. Each row of 120 words is permuted
// within itself and column p is delayed p%8 rows through a nine-row history
// memory. Output row t-1 leaves while input row t arrives; rows 0..7 of a
// frame give no output, data words that arrive during a drain are dropped.
// Throughput: one word per cycle while in_stall is low, set by the single
// write and single read port of the history memory. An accepted word passes
// the history read register, then a four-entry result queue that parts the
// sides; when the receiver stalls, the queue fills and in_stall rises once it
// and the read stage hold four words. Reset clears the row and column
// counters and the drain state at once; history contents need no clearing.
// ----------------------------------------------------------------------------
module block_convolutional_deinterleaver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  bcdi_pkg::bcdi_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bcdi_pkg::bcdi_out_t           out_data,
	input  logic                          cfg_wr_en,
	input  logic [bcdi_pkg::ROW_BITS-1:0] cfg_wr_data
);
	import bcdi_pkg::*;

	bcdi_req_t            req;
	bcdi_push_t           push;
	logic [QCNT_BITS-1:0] level;
	logic [QCNT_BITS:0]   used;

	assign used     = {1'b0, level} + (QCNT_BITS+1)'(push.valid);
	assign in_stall = (used >= (QCNT_BITS+1)'(QUEUE_DEPTH));

	bcdi_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req)
	);

	bcdi_hist u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.push   (push)
	);

	bcdi_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.level     (level)
	);

endmodule

>>> design/bcdi_checker.sv
// ----------------------------------------------------------------------------
// Block convolutional deinterleaver port checker
// Watches the top-level ports and flags output framing errors.
// ----------------------------------------------------------------------------
`include "block_convolutional_deinterleaver_defines.svh"

module bcdi_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_stall,
	input bcdi_pkg::bcdi_out_t out_data
);
	import bcdi_pkg::*;

	localparam logic [COL_BITS-1:0] LAST_COL = COL_BITS'(ROW_WORDS - 1);

	`BCDI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_data))
	`BCDI_ASSERT_NOW(a_row_end, clk, arst_n, out_valid,
		out_data.last_of_row == (out_data.out_column == LAST_COL))
	`BCDI_ASSERT_NOW(a_frame_end, clk, arst_n, out_valid && out_data.last_of_frame,
		out_data.last_of_row)
	`BCDI_ASSERT_NOW(a_col_range, clk, arst_n, out_valid,
		out_data.out_column < COL_BITS'(ROW_WORDS))

endmodule

bind block_convolutional_deinterleaver bcdi_checker u_bcdi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

>>> tb/deinterleaver_checker.sv
// ----------------------------------------------------------------------------
// Deinterleaver checker
// Watches the input, output and configuration ports of the deinterleaver and
// keeps its own copy of the row history, counters and drain state. Every
// accepted input word is run through that copy. Any word it predicts is queued.
// Each accepted output word is compared field by field with the oldest queued
// word. The failure count, the number of words still due and the number of
// words checked go to the top.
// ----------------------------------------------------------------------------
module deinterleaver_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  bcdi_pkg::bcdi_in_t            in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  bcdi_pkg::bcdi_out_t           out_data,
	input  logic                          cfg_wr_en,
	input  logic [bcdi_pkg::ROW_BITS-1:0] cfg_wr_data,
	output int                            errors,
	output int                            outstanding,
	output int                            words_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import bcdi_pkg::*;

	localparam int DELAY_SPAN = 8;

	logic [WORD_BITS-1:0] history [HIST_DEPTH];
	logic [COL_BITS-1:0]  col_in;
	logic [ROW_BITS-1:0]  row_in;
	logic                 draining;
	logic [COL_BITS-1:0]  col_drain;
	logic [ROW_BITS-1:0]  frame_rows_cfg;
	bcdi_out_t            due_words [$];

	function automatic logic [WORD_BITS-1:0] history_word(input int row, input int col);
		return history[(row % HIST_ROWS) * ROW_WORDS + col];
	endfunction

	task automatic deinterleave(input bcdi_in_t item);
		int        c;
		int        t;
		int        rows;
		int        dest;
		bcdi_out_t w;
		rows = (frame_rows_cfg < MIN_ROWS) ? MIN_ROWS : frame_rows_cfg;
		if (item.op == OP_DRAIN) begin
			if (draining) begin
				c = col_drain;
				w.out_word      = history_word(row_in - c % DELAY_SPAN, c);
				w.out_column    = COL_BITS'(c);
				w.last_of_row   = (c == ROW_WORDS - 1);
				w.last_of_frame = (c == ROW_WORDS - 1);
				due_words.push_back(w);
				if (c == ROW_WORDS - 1) begin
					draining  = 1'b0;
					col_drain = '0;
					row_in    = '0;
					col_in    = '0;
				end else begin
					col_drain = COL_BITS'(c + 1);
				end
			end
		end else if (!draining) begin
			c    = col_in;
			t    = row_in;
			dest = c / PERM_GROUP + PERM_STRIDE * (c % PERM_GROUP);
			if (t > FIRST_SENT_ROW) begin
				w.out_word      = history_word(t - 1 - c % DELAY_SPAN, c);
				w.out_column    = COL_BITS'(c);
				w.last_of_row   = (c == ROW_WORDS - 1);
				w.last_of_frame = 1'b0;
				due_words.push_back(w);
			end
			history[(t % HIST_ROWS) * ROW_WORDS + dest] = item.data_word;
			if (c == ROW_WORDS - 1) begin
				col_in = '0;
				if (t + 1 >= rows) begin
					draining  = 1'b1;
					col_drain = '0;
				end else begin
					row_in = ROW_BITS'(t + 1);
				end
			end else begin
				col_in = COL_BITS'(c + 1);
			end
		end
	endtask

	task automatic flag_field(input string field, input int exp_v, input int act_v);
		errors++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, act_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		bcdi_out_t want;
		if (!arst_n) begin
			col_in         = '0;
			row_in         = '0;
			draining       = 1'b0;
			col_drain      = '0;
			frame_rows_cfg = ROW_BITS'(RPF_RESET);
			due_words.delete();
			errors         = 0;
			words_checked  = 0;
		end else begin
			if (out_valid && !out_stall) begin
				words_checked++;
				if (due_words.size() == 0) begin
					errors++;
					$display("%0t: word with none due, expected nothing, got word %0d column %0d",
						$time, out_data.out_word, out_data.out_column);
				end else begin
					want = due_words.pop_front();
					if (out_data.out_word !== want.out_word)
						flag_field("out_word", want.out_word, out_data.out_word);
					if (out_data.out_column !== want.out_column)
						flag_field("out_column", want.out_column, out_data.out_column);
					if (out_data.last_of_row !== want.last_of_row)
						flag_field("last_of_row", want.last_of_row, out_data.last_of_row);
					if (out_data.last_of_frame !== want.last_of_frame)
						flag_field("last_of_frame", want.last_of_frame, out_data.last_of_frame);
				end
			end
			if (cfg_wr_en)
				frame_rows_cfg = cfg_wr_data;
			if (in_valid && !in_stall)
				deinterleave(in_data);
		end
		outstanding = due_words.size();
	end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Deinterleaver testbench
// Sends random words to the deinterleaver: nine rows at the reset frame
// length, then the length is set below the minimum mid-frame, which cuts the
// frame after the next row. Stray drain ticks and stray data words are mixed
// in. Both sides idle at random. One long receiver hold-off backs up the
// block. A checker beside the block predicts and compares every output word.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import bcdi_pkg::*;

	localparam int IDLE_PAUSE  = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 250;

	logic                clk;
	logic                arst_n;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	bcdi_in_t            in_data     = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	bcdi_out_t           out_data;
	logic                cfg_wr_en   = 1'b0;
	logic [ROW_BITS-1:0] cfg_wr_data = '0;

	int errors;
	int outstanding;
	int words_checked;
	int items_sent  = 0;
	int cycle_count = 0;

	block_convolutional_deinterleaver uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	deinterleaver_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.errors        (errors),
		.outstanding   (outstanding),
		.words_checked (words_checked)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// output side: one long hold-off, a quiet stretch, otherwise random stalls
	initial begin
		bit held;
		bit quiet;
		int n;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && words_checked >= 20) begin
				held = 1'b1;
				out_stall <= 1'b1;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(negedge clk);
			end
			quiet = words_checked >= 100 && words_checked < 260;
			out_stall <= !quiet && $urandom_range(99) < 36;
		end
	end

	task automatic put_word(input logic op, input logic [WORD_BITS-1:0] w);
		while (!(items_sent >= 300 && items_sent < 700) && $urandom_range(99) < 36) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid          <= 1'b1;
		in_data.op        <= op;
		in_data.data_word <= w;
		do @(posedge clk); while (in_stall);
		items_sent++;
		@(negedge clk);
	endtask

	// data words with the odd stray drain tick, which finds no row pending
	task automatic send_words(input int count);
		int k;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(99) < 3)
				put_word(OP_DRAIN, WORD_BITS'($urandom));
			put_word(OP_DATA, WORD_BITS'($urandom));
		end
	endtask

	// drain the last row; stray data words in between are dropped
	task automatic drain_row();
		int k;
		for (k = 0; k < ROW_WORDS; k++) begin
			if ($urandom_range(99) < 5)
				put_word(OP_DATA, WORD_BITS'($urandom));
			put_word(OP_DRAIN, WORD_BITS'($urandom));
		end
		put_word(OP_DRAIN, WORD_BITS'($urandom));
	endtask

	task automatic set_rows(input logic [ROW_BITS-1:0] rows);
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (IDLE_PAUSE) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= rows;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// drain ticks with no row pending, then data word extremes
		put_word(OP_DRAIN, 8'hFF);
		put_word(OP_DRAIN, 8'h00);
		put_word(OP_DATA, 8'h00);
		put_word(OP_DATA, 8'hFF);
		put_word(OP_DATA, 8'h55);
		put_word(OP_DATA, 8'hAA);
		put_word(OP_DATA, 8'h01);
		put_word(OP_DATA, 8'h80);
		put_word(OP_DATA, 8'hFE);
		put_word(OP_DATA, 8'h7F);
		send_words(9 * ROW_WORDS - 8);

		// below the minimum acts as the minimum, which cuts this frame short
		set_rows(ROW_BITS'(3));
		send_words(ROW_WORDS);
		drain_row();

		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		$display("Sent %0d words, checked %0d output words over ten rows of one frame,",
			items_sent, words_checked);
		$display("cut short mid-frame, with stray drains, dropped words and a hold-off");
		if (errors == 0 && outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/bcdi_pkg.sv
design/bcdi_front.sv
design/bcdi_hist.sv
design/bcdi_queue.sv
design/block_convolutional_deinterleaver.sv
design/bcdi_checker.sv
tb/deinterleaver_checker.sv
tb/testbench.sv
